// ----- rtl/bkit_pkg.sv -----
// bkit_pkg: shared types and constants of the bounded key/info table.
// Used by every module under rtl/; depends on nothing.
package bkit_pkg;

  localparam int CAPACITY    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int LIMIT_W     = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_REJECT    = 2'd2;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_RANGE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_COUNT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] key;
    logic [31:0]        info_handle;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_key;
    logic [31:0]        found_info;
    logic [4:0]         match_count;
    logic               table_full;
    logic               last;
  } res_t;

  // classified word held in the queue between front and back
  typedef struct packed {
    kind_t              op;
    logic               pre_fail;  // insert with zero key/handle, or reversed range
    logic signed [31:0] key;
    logic [31:0]        info;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } work_t;

endpackage

// ----- rtl/bounded_key_info_table_top.sv -----
// bounded_key_info_table_top: top level of the bounded key/info table.
// Instantiates bkit_front, bkit_queue and bkit_back; depends on bkit_pkg.
//
// Usage
//   Command channel: a word on cmd is taken at a clock edge where start is
//   high and busy is low. busy rises only when the two-word command queue
//   is full, so the front keeps taking words while the back is scanning.
//   Result channel: every result is on res for one cycle with res_valid
//   high; res.last marks the final result of a command. The receiver
//   cannot stall, results are never held back.
//   Config: cfg_we writes cfg_wdata into the capacity limit (reset 16);
//   write it only while no command is pending.
// Command execution
//   insert: passes through the queue slot and the result register; no scan.
//   lookup/delete: the back scans one entry a cycle until a match or the end.
//   range query: one full scan pass per distinct key in range to count
//   them, plus a final pass that finds none, then one pass per key emitted.
//   Sustained rate is set by the single entry-read scan port in the back.
// Reset: synchronous, clears the table (entry count 0) and the queue, and
//   loads 16 into the limit register; entry rows themselves are not cleared.
module bounded_key_info_table_top import bkit_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output logic               res_valid,
  output res_t               res
);

  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_valid;
  work_t push_word;
  work_t head_word;

  // front: accept and pre-classify (zero key/handle, reversed range)
  bkit_front u_front (
    .start  (start),
    .cmd    (cmd),
    .q_full (q_full),
    .busy   (busy),
    .push   (push),
    .word   (push_word)
  );

  // decouples command acceptance from the scanning back end
  bkit_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (head_word)
  );

  // back: storage, limit register, scan sequencer, result register
  bkit_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_word    (head_word),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

endmodule

// ----- rtl/bkit_front.sv -----
// bkit_front: accepts commands and classifies them into queue words.
// Depends on bkit_pkg.
module bkit_front import bkit_pkg::*; (
  input  logic  start,
  input  cmd_t  cmd,
  input  logic  q_full,
  output logic  busy,
  output logic  push,
  output work_t word
);

  kind_t op;

  assign op   = kind_t'(cmd.kind);
  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    word.op   = op;
    word.key  = cmd.key;
    word.info = cmd.info_handle;
    word.lo   = cmd.range_low;
    word.hi   = cmd.range_high;
    unique case (op)
      KIND_INSERT: word.pre_fail = (cmd.key == 32'sd0) || (cmd.info_handle == 32'd0);
      KIND_RANGE:  word.pre_fail = $signed(cmd.range_low) > $signed(cmd.range_high);
      default:     word.pre_fail = 1'b0;
    endcase
  end

endmodule

// ----- rtl/bkit_queue.sv -----
// bkit_queue: short register FIFO of classified words between front and back.
// Depends on bkit_pkg.
module bkit_queue import bkit_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_word,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output work_t head
);

  work_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;

  assign full  = (fill == QCNT_W'(QDEPTH));
  assign valid = (fill != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

// ----- rtl/bkit_back.sv -----
// bkit_back: entry storage, capacity register and the scanning sequencer
// that executes queued words and drives results. Depends on bkit_pkg.
module bkit_back import bkit_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               q_valid,
  input  work_t              q_word,
  output logic               pop,
  output logic               res_valid,
  output res_t               res
);

  state_t state, state_next;

  logic [LIMIT_W-1:0] limit;
  logic [CNT_W-1:0]   lim;

  logic signed [31:0] keys  [CAPACITY];
  logic [31:0]        infos [CAPACITY];

  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   idx, idx_next;
  work_t              cur, cur_next;
  logic               best_valid, best_valid_next;
  logic signed [31:0] best_key, best_key_next;
  logic [31:0]        best_info, best_info_next;
  logic signed [31:0] prev_key, prev_key_next;
  logic               started, started_next;
  logic [CNT_W-1:0]   total, total_next;
  logic [CNT_W-1:0]   emitted, emitted_next;
  logic [CNT_W-1:0]   emit_n;
  logic               res_valid_next;
  res_t               res_next;

  logic               wr_en;
  logic               shift_en;
  logic signed [31:0] scan_key;
  logic [31:0]        scan_info;
  logic               cand;
  logic               at_end;

  function automatic res_t mk_res(logic [1:0] st, logic signed [31:0] fk,
                                  logic [31:0] fi, logic [4:0] mc,
                                  logic full, logic lst);
    res_t r;
    r.status      = st;
    r.found_key   = fk;
    r.found_info  = fi;
    r.match_count = mc;
    r.table_full  = full;
    r.last        = lst;
    return r;
  endfunction

  // effective limit: register value clipped to the storage depth
  assign lim = (limit > LIMIT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(limit);

  assign scan_key  = keys[idx[IDX_W-1:0]];
  assign scan_info = infos[idx[IDX_W-1:0]];
  assign at_end    = (idx == count);
  assign emit_n    = (total > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : total;

  // next-smallest candidate in range, strictly above the last one taken
  assign cand = ($signed(scan_key) >= $signed(cur.lo)) &&
                ($signed(scan_key) <= $signed(cur.hi)) &&
                (!started || ($signed(scan_key) > $signed(prev_key))) &&
                (!best_valid || ($signed(scan_key) < $signed(best_key)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    idx_next        = idx;
    cur_next        = cur;
    best_valid_next = best_valid;
    best_key_next   = best_key;
    best_info_next  = best_info;
    prev_key_next   = prev_key;
    started_next    = started;
    total_next      = total;
    emitted_next    = emitted;
    res_valid_next  = 1'b0;
    res_next        = res;
    pop             = 1'b0;
    wr_en           = 1'b0;
    shift_en        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          pop             = 1'b1;
          cur_next        = q_word;
          idx_next        = '0;
          best_valid_next = 1'b0;
          started_next    = 1'b0;
          total_next      = '0;
          emitted_next    = '0;
          unique case (q_word.op)
            KIND_INSERT: begin
              res_valid_next = 1'b1;
              if (q_word.pre_fail || (count >= lim)) begin
                res_next = mk_res(ST_REJECT, '0, '0, '0, count >= lim, 1'b1);
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
                res_next   = mk_res(ST_OK, '0, '0, '0,
                                    (count + CNT_W'(1)) >= lim, 1'b1);
              end
            end
            KIND_LOOKUP, KIND_DELETE: begin
              state_next = S_FIND;
            end
            KIND_RANGE: begin
              if (q_word.pre_fail) begin
                res_valid_next = 1'b1;
                res_next = mk_res(ST_NOT_FOUND, '0, '0, '0, count >= lim, 1'b1);
              end else begin
                state_next = S_COUNT;
              end
            end
          endcase
        end
      end

      S_FIND: begin
        if (at_end) begin
          res_valid_next = 1'b1;
          res_next   = mk_res(ST_NOT_FOUND, '0, '0, '0, count >= lim, 1'b1);
          state_next = S_IDLE;
        end else if (scan_key == cur.key) begin
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
          if (cur.op == KIND_LOOKUP) begin
            res_next = mk_res(ST_OK, '0, scan_info, '0, count >= lim, 1'b1);
          end else begin
            shift_en   = 1'b1;
            count_next = count - CNT_W'(1);
            res_next   = mk_res(ST_OK, '0, '0, '0, (count - CNT_W'(1)) >= lim, 1'b1);
          end
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      S_COUNT: begin
        if (at_end) begin
          idx_next        = '0;
          best_valid_next = 1'b0;
          if (best_valid) begin
            total_next    = total + CNT_W'(1);
            prev_key_next = best_key;
            started_next  = 1'b1;
          end else if (total == '0) begin
            res_valid_next = 1'b1;
            res_next   = mk_res(ST_NOT_FOUND, '0, '0, '0, count >= lim, 1'b1);
            state_next = S_IDLE;
          end else begin
            started_next = 1'b0;
            emitted_next = '0;
            state_next   = S_EMIT;
          end
        end else begin
          if (cand) begin
            best_valid_next = 1'b1;
            best_key_next   = scan_key;
            best_info_next  = scan_info;
          end
          idx_next = idx + CNT_W'(1);
        end
      end

      S_EMIT: begin
        if (at_end) begin
          res_valid_next  = 1'b1;
          res_next        = mk_res(ST_OK, best_key, best_info, 5'(total), count >= lim,
                                   (emitted + CNT_W'(1)) == emit_n);
          idx_next        = '0;
          best_valid_next = 1'b0;
          prev_key_next   = best_key;
          started_next    = 1'b1;
          emitted_next    = emitted + CNT_W'(1);
          if ((emitted + CNT_W'(1)) == emit_n) begin
            state_next = S_IDLE;
          end
        end else begin
          if (cand) begin
            best_valid_next = 1'b1;
            best_key_next   = scan_key;
            best_info_next  = scan_info;
          end
          idx_next = idx + CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_RESET;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      count     <= count_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    cur        <= cur_next;
    best_valid <= best_valid_next;
    best_key   <= best_key_next;
    best_info  <= best_info_next;
    prev_key   <= prev_key_next;
    started    <= started_next;
    total      <= total_next;
    emitted    <= emitted_next;
    res        <= res_next;
  end

  // entry rows: append at the fill point, delete pulls upper rows down by one
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (wr_en && (count[IDX_W-1:0] == IDX_W'(i))) begin
        keys[i]  <= q_word.key;
        infos[i] <= q_word.info;
      end else if (shift_en && (i < CAPACITY - 1) &&
                   (IDX_W'(i) >= idx[IDX_W-1:0])) begin
        keys[i]  <= keys[(i + 1) % CAPACITY];
        infos[i] <= infos[(i + 1) % CAPACITY];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |-> state == S_IDLE)
    else $error("final result while sequencer still busy");

  a_more_emit: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> state == S_EMIT)
    else $error("non-final result outside range emission");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count)) ||
                    (count == $past(count) + CNT_W'(1)) ||
                    (count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    res_valid && cur.op == KIND_INSERT && res.status == ST_OK |->
    count == $past(count) + CNT_W'(1))
    else $error("accepted insert did not grow the table");

  a_delete_shrink: assert property (@(posedge clk) disable iff (rst)
    res_valid && cur.op == KIND_DELETE && res.status == ST_OK |->
    count == $past(count) - CNT_W'(1))
    else $error("successful delete did not shrink the table");
`endif

endmodule
